### design/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared constants and types for the sensor frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

  localparam logic [7:0]  HdrByte = 8'hAA;
  localparam logic [7:0]  HdrSum  = 8'h54;
  localparam logic [7:0]  RecBytes = 8'd34;
  localparam int unsigned RecW    = 272;

  typedef logic [RecW-1:0] rec_t;

  typedef struct packed {
    logic valid;
    rec_t data;
  } rec_push_t;

endpackage

`default_nettype wire

### design/sfd_front.sv
// ----------------------------------------------------------------------------
// sfd_front
// Per-word frame parser: header hunt, checksum and payload capture.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire logic [7:0]        rx_byte_i,
  output sfd_pkg::rec_push_t     push_o
);
  import sfd_pkg::*;

  localparam logic [2:0] PhHunt1 = 3'd0;
  localparam logic [2:0] PhHunt2 = 3'd1;
  localparam logic [2:0] PhCode  = 3'd2;
  localparam logic [2:0] PhLen   = 3'd3;
  localparam logic [2:0] PhData  = 3'd4;
  localparam logic [2:0] PhSum   = 3'd5;

  logic [2:0] phase_q, phase_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] len_q, len_d;
  logic [7:0] cnt_q, cnt_d;
  rec_t       shift_q, shift_d;
  logic [7:0] cnt_inc;

  assign cnt_inc = cnt_q + 8'd1;

  always_comb begin
    phase_d = phase_q;
    sum_d   = sum_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    if (valid_i) begin
      unique case (phase_q)
        PhHunt2: begin
          if (rx_byte_i == HdrByte) begin
            sum_d   = HdrSum;
            phase_d = PhCode;
          end else begin
            phase_d = PhHunt1;
          end
        end
        PhCode: begin
          sum_d   = sum_q + rx_byte_i;
          phase_d = PhLen;
        end
        PhLen: begin
          sum_d   = sum_q + rx_byte_i;
          len_d   = rx_byte_i;
          cnt_d   = 8'd0;
          phase_d = (rx_byte_i == 8'd0) ? PhSum : PhData;
        end
        PhData: begin
          sum_d = sum_q + rx_byte_i;
          if (cnt_q < RecBytes) begin
            shift_d = {shift_q[RecW-9:0], rx_byte_i};
          end
          cnt_d = cnt_inc;
          if (cnt_inc == len_q) begin
            phase_d = PhSum;
          end
        end
        PhSum: begin
          phase_d = PhHunt1;
        end
        default: begin
          phase_d = (rx_byte_i == HdrByte) ? PhHunt2 : PhHunt1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt1;
      sum_q   <= 8'd0;
      len_q   <= 8'd0;
      cnt_q   <= 8'd0;
    end else begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
    end
  end

  // payload shift line, byte 0 ends up in the top bits
  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
  end

  assign push_o.valid = valid_i && (phase_q == PhSum) && (rx_byte_i == sum_q) &&
                        (len_q >= RecBytes);
  assign push_o.data  = shift_q;

  a_push_from_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.valid |-> (phase_q == PhSum) && valid_i)
    else $error("record pushed outside checksum phase");

  a_hunt_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.valid |=> (phase_q == PhHunt1))
    else $error("parser not hunting after record");

  a_data_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhData) |-> (len_q != 8'd0) && (cnt_q < len_q))
    else $error("payload count out of range");

endmodule

`default_nettype wire

### design/sfd_back.sv
// ----------------------------------------------------------------------------
// sfd_back
// Record queue and field decode towards the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_back #(
  parameter int unsigned Depth = 2
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire sfd_pkg::rec_push_t  push_i,
  input  wire logic                pop_i,
  output logic                     full_o,
  output logic                     empty_o,
  output logic signed [31:0]       odom_left_o,
  output logic signed [31:0]       odom_right_o,
  output logic signed [15:0]       speed_left_o,
  output logic signed [15:0]       speed_right_o,
  output logic [31:0]              sonar_one_o,
  output logic [31:0]              sonar_two_o,
  output logic [31:0]              sonar_three_o,
  output logic [31:0]              infrared_one_o,
  output logic [31:0]              infrared_two_o,
  output logic [7:0]               switch_one_o,
  output logic [7:0]               switch_two_o
);
  import sfd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  rec_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_pop;
  rec_t            head;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i.valid && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i.valid && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.data;
    end
  end

  assign head = mem_q[rd_ptr_q];

  assign odom_left_o    = signed'(head[271:240]);
  assign odom_right_o   = signed'(head[239:208]);
  assign speed_left_o   = signed'(head[207:192]);
  assign speed_right_o  = signed'(head[191:176]);
  assign sonar_one_o    = head[175:144];
  assign sonar_two_o    = head[143:112];
  assign sonar_three_o  = head[111:80];
  assign infrared_one_o = head[79:48];
  assign infrared_two_o = head[47:16];
  assign switch_one_o   = head[15:8];
  assign switch_two_o   = head[7:0];

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("queue count above depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> !full_o)
    else $error("record pushed into full queue");

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !push_i.valid) |=> (cnt_q == $past(cnt_q) - 1'b1))
    else $error("queue count not reduced on pop");

endmodule

`default_nettype wire

### design/sensor_frame_deframer.sv
// ----------------------------------------------------------------------------
// sensor_frame_deframer
// Serial sensor frame parser with a queued record output.
// ----------------------------------------------------------------------------
// Takes one received word per cycle with no gaps needed: 0xAA 0xAA, function
// code, length, payload and an additive 8-bit checksum. A frame whose checksum
// matches and whose payload holds at least 34 bytes yields one record, decoded
// big-endian from payload bytes 0 to 33; all other frames are dropped. The
// record is available on the cycle after its checksum word is taken. Records
// wait in a QueueDepth-entry queue; full_o is raised only while that queue is
// full, and then no word is taken until a record is popped.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_frame_deframer #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  wire logic [7:0]          rx_byte_i,
  output logic                     empty,
  input  wire logic                pop,
  output logic signed [31:0]       odom_left_o,
  output logic signed [31:0]       odom_right_o,
  output logic signed [15:0]       speed_left_o,
  output logic signed [15:0]       speed_right_o,
  output logic [31:0]              sonar_one_o,
  output logic [31:0]              sonar_two_o,
  output logic [31:0]              sonar_three_o,
  output logic [31:0]              infrared_one_o,
  output logic [31:0]              infrared_two_o,
  output logic [7:0]               switch_one_o,
  output logic [7:0]               switch_two_o
);
  import sfd_pkg::*;

  logic      accept;
  rec_push_t rec_push;

  assign accept = push && !full;

  sfd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (accept),
    .rx_byte_i (rx_byte_i),
    .push_o    (rec_push)
  );

  sfd_back #(
    .Depth (QueueDepth)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (rec_push),
    .pop_i          (pop),
    .full_o         (full),
    .empty_o        (empty),
    .odom_left_o    (odom_left_o),
    .odom_right_o   (odom_right_o),
    .speed_left_o   (speed_left_o),
    .speed_right_o  (speed_right_o),
    .sonar_one_o    (sonar_one_o),
    .sonar_two_o    (sonar_two_o),
    .sonar_three_o  (sonar_three_o),
    .infrared_one_o (infrared_one_o),
    .infrared_two_o (infrared_two_o),
    .switch_one_o   (switch_one_o),
    .switch_two_o   (switch_two_o)
  );

endmodule

`default_nettype wire
